@@ design/imc_pkg.sv @@
// Shared constants and IUPAC decode functions for the IUPAC mismatch counter.
package imc_pkg;

  localparam int unsigned MaxLength = 1024;
  localparam int unsigned CountW    = $clog2(MaxLength + 1);
  localparam int unsigned CharW     = 8;

  localparam logic [CharW-1:0] SkipChar   = 8'h4E;  // uppercase N
  localparam logic [CharW-1:0] LowerFirst = 8'h61;  // 'a'
  localparam logic [CharW-1:0] LowerLast  = 8'h7A;  // 'z'
  localparam logic [CharW-1:0] CaseOffset = 8'h20;

  localparam logic [CharW-1:0] ChA = 8'h41;
  localparam logic [CharW-1:0] ChB = 8'h42;
  localparam logic [CharW-1:0] ChC = 8'h43;
  localparam logic [CharW-1:0] ChD = 8'h44;
  localparam logic [CharW-1:0] ChG = 8'h47;
  localparam logic [CharW-1:0] ChH = 8'h48;
  localparam logic [CharW-1:0] ChK = 8'h4B;
  localparam logic [CharW-1:0] ChM = 8'h4D;
  localparam logic [CharW-1:0] ChR = 8'h52;
  localparam logic [CharW-1:0] ChS = 8'h53;
  localparam logic [CharW-1:0] ChT = 8'h54;
  localparam logic [CharW-1:0] ChV = 8'h56;
  localparam logic [CharW-1:0] ChW = 8'h57;
  localparam logic [CharW-1:0] ChX = 8'h58;
  localparam logic [CharW-1:0] ChY = 8'h59;

  // Base set: bit 0 = A, bit 1 = C, bit 2 = G, bit 3 = T.
  typedef logic [3:0] base_set_t;

  localparam base_set_t SetNone = 4'b0000;
  localparam base_set_t SetA    = 4'b0001;
  localparam base_set_t SetC    = 4'b0010;
  localparam base_set_t SetG    = 4'b0100;
  localparam base_set_t SetT    = 4'b1000;
  localparam base_set_t SetAll  = 4'b1111;

  function automatic logic [CharW-1:0] to_upper(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= LowerFirst && c <= LowerLast) begin
      r = c - CaseOffset;
    end
    return r;
  endfunction

  function automatic base_set_t pattern_set(input logic [CharW-1:0] p);
    logic [CharW-1:0] c;
    base_set_t        s;
    c = to_upper(p);
    unique case (c)
      ChA:     s = SetA;
      ChC:     s = SetC;
      ChM:     s = SetA | SetC;
      ChG:     s = SetG;
      ChR:     s = SetA | SetG;
      ChS:     s = SetC | SetG;
      ChV:     s = SetA | SetC | SetG;
      ChT:     s = SetT;
      ChW:     s = SetA | SetT;
      ChY:     s = SetC | SetT;
      ChH:     s = SetA | SetC | SetT;
      ChK:     s = SetG | SetT;
      ChD:     s = SetA | SetG | SetT;
      ChB:     s = SetC | SetG | SetT;
      ChX:     s = SetNone;
      default: s = SetAll;
    endcase
    return s;
  endfunction

  function automatic base_set_t seq_base_bit(input logic [CharW-1:0] q);
    logic [CharW-1:0] c;
    base_set_t        s;
    c = to_upper(q);
    unique case (c)
      ChA:     s = SetA;
      ChC:     s = SetC;
      ChG:     s = SetG;
      ChT:     s = SetT;
      default: s = SetNone;
    endcase
    return s;
  endfunction

endpackage

@@ design/iupac_mismatch_counter.sv @@
// Top level of the IUPAC pattern mismatch counter.
//
// Usage: each input transaction carries one read-sequence byte, the pattern
// byte at the same position and a last flag marking the final position.
// The block counts positions where the sequence byte is not one of the bases
// the pattern code allows; an uppercase N in the pattern skips the position.
// The count saturates at MaxLength and one output transaction with the count
// is produced for each input transaction that has last set; the count is then
// cleared for the next sequence.
//
// Timing: one input transaction is taken every cycle, except while a last
// position waits in the input register for the result register to free up.
// Each transaction is captured in the input register and compared and
// counted from there; the count of a last position is then written into the
// result register, which presents it on the output.
//
// Reset clears the running count and both valid flags. When the receiver
// stalls, the result register holds its count and the input register can
// still take one more transaction; positions without last keep flowing into
// the count while the result waits.
module iupac_mismatch_counter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [imc_pkg::CharW-1:0]  seq_char_i,
  input  logic [imc_pkg::CharW-1:0]  pattern_char_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [imc_pkg::CountW-1:0] mismatch_count_o
);

  // Input register stage.
  logic                      s1_valid_q;
  logic [imc_pkg::CharW-1:0] s1_seq_q;
  logic [imc_pkg::CharW-1:0] s1_pat_q;
  logic                      s1_last_q;

  // Running count and result register.
  logic [imc_pkg::CountW-1:0] count_q, count_d;
  logic [imc_pkg::CountW-1:0] count_inc;
  logic                       out_valid_q, out_valid_d;
  logic [imc_pkg::CountW-1:0] out_count_q, out_count_d;

  logic s1_miss;
  logic out_free;
  logic s1_adv;
  logic in_accept;

  // The result slot is free if empty or being drained this cycle.
  assign out_free  = !out_valid_q || out_ready_i;
  // A position without last never needs the result slot, so it always moves.
  assign s1_adv    = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_seq_q  <= seq_char_i;
      s1_pat_q  <= pattern_char_i;
      s1_last_q <= last_i;
    end
  end

  imc_match u_match (
    .seq_char_i     (s1_seq_q),
    .pattern_char_i (s1_pat_q),
    .miss_o         (s1_miss)
  );

  // Saturating increment of the running count.
  always_comb begin
    count_inc = count_q;
    if (s1_miss && (count_q < imc_pkg::CountW'(imc_pkg::MaxLength))) begin
      count_inc = count_q + imc_pkg::CountW'(1);
    end
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_count_d = out_count_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        count_d     = '0;
        out_valid_d = 1'b1;
        out_count_d = count_inc;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign mismatch_count_o = out_count_q;

  // The running count never passes the saturation limit.
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= imc_pkg::CountW'(imc_pkg::MaxLength))
    else $error("running count above limit");

  // Closing a sequence clears the count for the next one.
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (count_q == '0))
    else $error("count not cleared after last position");

  // Closing a sequence always presents a result in the next cycle.
  a_result_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> out_valid_o)
    else $error("no result after last position");

  // A last position is never moved on while an older result still blocks.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(s1_adv && s1_last_q))
    else $error("result overwritten while stalled");

endmodule

@@ design/imc_match.sv @@
// Per-position compare of a sequence byte against an IUPAC pattern byte.
module imc_match (
  input  logic [imc_pkg::CharW-1:0] seq_char_i,
  input  logic [imc_pkg::CharW-1:0] pattern_char_i,
  output logic                      miss_o
);

  imc_pkg::base_set_t pat_set;
  imc_pkg::base_set_t seq_bit;

  assign pat_set = imc_pkg::pattern_set(pattern_char_i);
  assign seq_bit = imc_pkg::seq_base_bit(seq_char_i);

  // Uppercase N is skipped entirely; otherwise an unknown sequence byte always misses.
  assign miss_o = (pattern_char_i != imc_pkg::SkipChar) &&
                  ((seq_bit == imc_pkg::SetNone) ||
                   ((pat_set & seq_bit) == imc_pkg::SetNone));

endmodule
